>>> rtl/gmdt_pkg.sv
// Package for the gyro motion distance tracker.
// Holds the port payload types, register indexes, reset values and state types.
// No dependencies.
package gmdt_pkg;

	// Fixed field and register widths.
	localparam int AXES        = 3;
	localparam int SAMPLE_W    = 16;
	localparam int MOTION_TH_W = 18;
	localparam int STEP_TH_W   = 39;
	localparam int SCALE_W     = 32;
	localparam int CFG_W       = 39;
	localparam int CFG_IDX_W   = 2;
	localparam int MAG_OUT_W   = 20;
	localparam int COUNT_W     = 16;
	localparam int TOTAL_W     = 48;
	localparam int DIST_W      = 32;
	// The magnitude total is multiplied in two halves split at this bit.
	localparam int SPLIT_W     = 24;

	localparam int DEF_WINDOW_DEPTH = 6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD_SQ = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE    = 2'd2;

	// Configuration reset values.
	localparam logic [MOTION_TH_W-1:0] MOTION_TH_RST = 18'd145;
	localparam logic [STEP_TH_W-1:0]   STEP_TH_RST   = 39'd14824000;
	localparam logic [SCALE_W-1:0]     SCALE_RST     = 32'd312338612;

	// One input transaction.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_x;
		logic signed [SAMPLE_W-1:0] sample_y;
		logic signed [SAMPLE_W-1:0] sample_z;
	} sample_t;

	// One result transaction.
	typedef struct packed {
		logic                 measuring;
		logic                 distance_taken;
		logic [MAG_OUT_W-1:0] step_magnitude;
		logic [COUNT_W-1:0]   step_count;
		logic [DIST_W-1:0]    total_distance_mm;
	} result_t;

	// Classification of one sample as handed from the front to the back.
	typedef struct packed {
		logic measure;    // this sample takes a distance step
		logic measuring;  // mode after this sample
	} job_ctl_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_UPDATE,
		F_CLASSIFY
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DIFF,
		B_SQUARE,
		B_ACCUM,
		B_ROOT,
		B_UPDATE,
		B_MUL_LO,
		B_MUL_HI,
		B_FINISH
	} back_state_t;

endpackage

>>> rtl/gyro_motion_distance_tracker_core.sv
// Gyro motion distance tracker, top level: configuration registers, front, queue, back.
// Front: registers a sample, updates the window sums, classifies it and waits for queue room.
// Back: for a measuring sample the per-axis difference, square and sum, then the serial square
// root, which sets its pace, and the totals; for every sample the scaling to millimetres.
// Each part takes a new sample only once it has passed the last one on. Reset is asynchronous
// and clears control state and totals; window entries read as zero until written.
module gyro_motion_distance_tracker_core #(
	parameter int WINDOW_DEPTH = gmdt_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  gmdt_pkg::sample_t                sample,
	output logic                             empty,
	input  logic                             pop,
	output gmdt_pkg::result_t                result,
	input  logic                             cfg_wr_en,
	input  logic [gmdt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gmdt_pkg::CFG_W-1:0]       cfg_wdata
);
	import gmdt_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int JOB_W = $bits(job_ctl_t) + AXES * SUM_W;

	logic [MOTION_TH_W-1:0] motion_threshold_q;
	logic [STEP_TH_W-1:0] step_threshold_sq_q;
	logic [SCALE_W-1:0] distance_scale_q;

	job_ctl_t f_ctl, b_ctl;
	logic [AXES-1:0][SUM_W-1:0] f_sums, b_sums;
	logic [JOB_W-1:0] q_wdata, q_rdata;
	logic q_push, q_full, q_pop, q_empty;

	// Configuration registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_threshold_q  <= MOTION_TH_RST;
			step_threshold_sq_q <= STEP_TH_RST;
			distance_scale_q    <= SCALE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MOTION_THRESHOLD:  motion_threshold_q  <= cfg_wdata[MOTION_TH_W-1:0];
				REG_STEP_THRESHOLD_SQ: step_threshold_sq_q <= cfg_wdata[STEP_TH_W-1:0];
				REG_DISTANCE_SCALE:    distance_scale_q    <= cfg_wdata[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gmdt_front #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SUM_W        (SUM_W)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.sample           (sample),
		.motion_threshold (motion_threshold_q),
		.job_push         (q_push),
		.job_full         (q_full),
		.job_ctl          (f_ctl),
		.job_sums         (f_sums)
	);

	// Classified samples wait here until the back part is free.
	assign q_wdata = {f_ctl, f_sums};
	assign {b_ctl, b_sums} = q_rdata;

	gmdt_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd_en  (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	gmdt_back #(
		.SUM_W (SUM_W)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.job_empty         (q_empty),
		.job_pop           (q_pop),
		.job_ctl           (b_ctl),
		.job_sums          (b_sums),
		.step_threshold_sq (step_threshold_sq_q),
		.distance_scale    (distance_scale_q),
		.empty             (empty),
		.pop               (pop),
		.result            (result)
	);

endmodule

>>> rtl/gmdt_front.sv
// Front part of the gyro motion distance tracker: accepts samples, keeps the
// moving window and its sums, and classifies each sample by the motion mode.
// Depends on gmdt_pkg.
module gmdt_front #(
	parameter int WINDOW_DEPTH = gmdt_pkg::DEF_WINDOW_DEPTH,
	parameter int SUM_W        = gmdt_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  gmdt_pkg::sample_t                      sample,
	input  logic [gmdt_pkg::MOTION_TH_W-1:0]       motion_threshold,
	output logic                                   job_push,
	input  logic                                   job_full,
	output gmdt_pkg::job_ctl_t                     job_ctl,
	output logic [gmdt_pkg::AXES-1:0][SUM_W-1:0]   job_sums
);
	import gmdt_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CMP_W = (SUM_W > MOTION_TH_W) ? SUM_W : MOTION_TH_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

	front_state_t state_q, state_d;
	sample_t samp_q;
	sample_t mem [WINDOW_DEPTH];
	sample_t rd_q;
	logic rd_vld_q;
	logic [WINDOW_DEPTH-1:0] vld_q;
	logic [PTR_W-1:0] ptr_q;
	logic [AXES-1:0][SUM_W-1:0] sums_q, sums_d;
	logic [AXES-1:0][SAMPLE_W-1:0] new_s, old_s;
	logic [AXES-1:0][SUM_W-1:0] abs_s;
	logic mode_q;
	logic hit;
	logic accept;

	assign accept = push && !full;

	// Window entries that were never written read as zero.
	assign new_s = {samp_q.sample_x, samp_q.sample_y, samp_q.sample_z};
	assign old_s = rd_vld_q ? {rd_q.sample_x, rd_q.sample_y, rd_q.sample_z} : '0;

	// Window sum update: add the new sample and drop the oldest one.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sums_d[a] = sums_q[a] + SUM_W'($signed(new_s[a])) - SUM_W'($signed(old_s[a]));
		end
	end

	// Motion detection on the absolute window sums.
	always_comb begin
		hit = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			abs_s[a] = sums_q[a][SUM_W-1] ? (~sums_q[a] + 1'b1) : sums_q[a];
			if (CMP_W'(abs_s[a]) >= CMP_W'(motion_threshold)) begin
				hit = 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (push) begin
					state_d = F_UPDATE;
				end
			end
			F_UPDATE: begin
				state_d = F_CLASSIFY;
			end
			F_CLASSIFY: begin
				if (!job_full) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		full              = (state_q != F_IDLE);
		job_push          = (state_q == F_CLASSIFY) && !job_full;
		job_ctl.measure   = mode_q;
		job_ctl.measuring = !mode_q && hit;
		job_sums          = sums_q;
	end

	// Control state, window sums and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			ptr_q    <= '0;
			sums_q   <= '0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			mode_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= vld_q[ptr_q];
			if (state_q == F_UPDATE) begin
				sums_q       <= sums_d;
				vld_q[ptr_q] <= 1'b1;
				ptr_q        <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			end
			if (job_push) begin
				mode_q <= job_ctl.measuring;
			end
		end
	end

	// Window memory with registered read at the current pointer.
	always_ff @(posedge clk) begin
		if (state_q == F_UPDATE) begin
			mem[ptr_q] <= samp_q;
		end
		rd_q <= mem[ptr_q];
	end

	// Sample capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= sample;
		end
	end

endmodule

>>> rtl/gmdt_queue.sv
// Two-entry queue that decouples the front and back parts of the tracker.
// Depends on no other file.
module gmdt_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr, do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = mem[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/gmdt_back.sv
// Back part of the tracker: squared distance, bit-serial square root, step and
// magnitude bookkeeping, scaling to millimetres and the result register.
// Depends on gmdt_pkg.
module gmdt_back #(
	parameter int SUM_W = gmdt_pkg::SAMPLE_W + $clog2(gmdt_pkg::DEF_WINDOW_DEPTH)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 job_empty,
	output logic                                 job_pop,
	input  gmdt_pkg::job_ctl_t                   job_ctl,
	input  logic [gmdt_pkg::AXES-1:0][SUM_W-1:0] job_sums,
	input  logic [gmdt_pkg::STEP_TH_W-1:0]       step_threshold_sq,
	input  logic [gmdt_pkg::SCALE_W-1:0]         distance_scale,
	output logic                                 empty,
	input  logic                                 pop,
	output gmdt_pkg::result_t                    result
);
	import gmdt_pkg::*;

	localparam int SQ_W     = 2 * SUM_W + 2;
	localparam int ROOT_W   = SQ_W / 2;
	localparam int ITER_W   = $clog2(ROOT_W + 1);
	localparam int AX_W     = $clog2(AXES);
	localparam int TH_CMP_W = (SQ_W > STEP_TH_W) ? SQ_W : STEP_TH_W;
	localparam int MAG_CMP_W = (ROOT_W > MAG_OUT_W) ? ROOT_W : MAG_OUT_W;
	localparam int LO_PROD_W = SPLIT_W + SCALE_W;
	localparam int HI_PROD_W = TOTAL_W - SPLIT_W + SCALE_W;
	localparam int PROD_W   = TOTAL_W + SCALE_W;
	localparam int DSUM_W   = PROD_W - SCALE_W;
	localparam logic [AX_W-1:0]   AX_LAST   = AX_W'(AXES - 1);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_W - 1);

	back_state_t state_q, state_d;
	job_ctl_t ctl_q;
	logic [AXES-1:0][SUM_W-1:0] sums_q, ref_q;
	logic [AX_W-1:0] ax_q;
	logic [SUM_W:0] diff;
	logic [SUM_W:0] diff_abs;
	logic [SUM_W-1:0] ad_q;
	logic [2*SUM_W-1:0] sq_q;
	logic [SQ_W-1:0] acc_q, acc_next;
	logic [SQ_W-1:0] rad_q;
	logic [ROOT_W:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+2:0] rem_sh, trial, rem_sub;
	logic [ITER_W-1:0] it_q;
	logic big_q;
	logic [COUNT_W-1:0] steps_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0] total_sum;
	logic [LO_PROD_W-1:0] pl_q;
	logic [HI_PROD_W-1:0] ph_q;
	logic [PROD_W-1:0] prod;
	logic [DSUM_W-1:0] dist_full;
	logic [DIST_W-1:0] dist_sat;
	logic [MAG_OUT_W-1:0] mag_sat;
	result_t out_q;
	logic out_vld_q;
	logic finish;

	// Absolute difference of one axis sum against its reference.
	assign diff = {sums_q[ax_q][SUM_W-1], sums_q[ax_q]} - {ref_q[ax_q][SUM_W-1], ref_q[ax_q]};
	assign diff_abs = diff[SUM_W] ? (~diff + 1'b1) : diff;

	assign acc_next = acc_q + SQ_W'(sq_q);

	// One restoring square root step: bring down two radicand bits.
	assign rem_sh  = {rem_q, rad_q[SQ_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_sub = rem_sh - trial;

	// Saturating magnitude accumulation.
	assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(root_q);

	// Millimetres: upper part of total times scale, saturated.
	assign prod      = {ph_q, {SPLIT_W{1'b0}}} + PROD_W'(pl_q);
	assign dist_full = prod[PROD_W-1:SCALE_W];
	assign dist_sat  = (dist_full[DSUM_W-1:DIST_W] != '0) ? '1 : dist_full[DIST_W-1:0];

	assign mag_sat = (MAG_CMP_W'(root_q) > MAG_CMP_W'({MAG_OUT_W{1'b1}})) ?
		'1 : MAG_OUT_W'(root_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					state_d = job_ctl.measure ? B_DIFF : B_MUL_LO;
				end
			end
			B_DIFF: begin
				state_d = B_SQUARE;
			end
			B_SQUARE: begin
				state_d = B_ACCUM;
			end
			B_ACCUM: begin
				state_d = (ax_q == AX_LAST) ? B_ROOT : B_DIFF;
			end
			B_ROOT: begin
				if (it_q == ITER_LAST) begin
					state_d = B_UPDATE;
				end
			end
			B_UPDATE: begin
				state_d = B_MUL_LO;
			end
			B_MUL_LO: begin
				state_d = B_MUL_HI;
			end
			B_MUL_HI: begin
				state_d = B_FINISH;
			end
			B_FINISH: begin
				if (!out_vld_q) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		job_pop = (state_q == B_IDLE) && !job_empty;
		finish  = (state_q == B_FINISH) && !out_vld_q;
		empty   = !out_vld_q;
		result  = out_q;
	end

	// Control state, reference sums and running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			ax_q      <= '0;
			it_q      <= '0;
			ref_q     <= '0;
			steps_q   <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				B_IDLE: begin
					ax_q <= '0;
				end
				B_ACCUM: begin
					ax_q <= ax_q + 1'b1;
					it_q <= '0;
					if (ax_q == AX_LAST) begin
						ref_q <= sums_q;
					end
				end
				B_ROOT: begin
					it_q <= it_q + 1'b1;
				end
				B_UPDATE: begin
					if (big_q && (steps_q != '1)) begin
						steps_q <= steps_q + 1'b1;
					end
					total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
				end
				default: begin
				end
			endcase
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ctl_q  <= job_ctl;
				sums_q <= job_sums;
				acc_q  <= '0;
			end
			B_DIFF: begin
				ad_q <= diff_abs[SUM_W-1:0];
			end
			B_SQUARE: begin
				sq_q <= ad_q * ad_q;
			end
			B_ACCUM: begin
				acc_q  <= acc_next;
				rad_q  <= acc_next;
				rem_q  <= '0;
				root_q <= '0;
				big_q  <= (TH_CMP_W'(acc_next) >= TH_CMP_W'(step_threshold_sq));
			end
			B_ROOT: begin
				rad_q <= {rad_q[SQ_W-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sub[ROOT_W:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[ROOT_W:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			B_MUL_LO: begin
				pl_q <= total_q[SPLIT_W-1:0] * distance_scale;
			end
			B_MUL_HI: begin
				ph_q <= total_q[TOTAL_W-1:SPLIT_W] * distance_scale;
			end
			B_FINISH: begin
				if (!out_vld_q) begin
					out_q.measuring         <= ctl_q.measuring;
					out_q.distance_taken    <= ctl_q.measure;
					out_q.step_magnitude    <= ctl_q.measure ? mag_sat : '0;
					out_q.step_count        <= steps_q;
					out_q.total_distance_mm <= dist_sat;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sim/tb_gyro_motion_distance_tracker_core.sv
// Self-checking testbench for gyro_motion_distance_tracker_core.
// A scoreboard model of the moving-window step tracker predicts every result transaction.
// Depends on rtl/gmdt_pkg.sv and rtl/gyro_motion_distance_tracker_core.sv.
`timescale 1ns / 100ps

module tb_gyro_motion_distance_tracker_core;
	import gmdt_pkg::*;

	localparam int DEPTH          = DEF_WINDOW_DEPTH;
	localparam int SETTLE_CYCLES  = 60;
	localparam int HOLD_CYCLES    = 600;
	localparam int STALL_LIMIT    = 5000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [SAMPLE_W-1:0] RATE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] RATE_MIN = 16'sh8000;
	localparam logic [STEP_TH_W-1:0] STEP_SQ_MAX = '1;

	typedef enum int {GEN_QUIET, GEN_WIDE, GEN_EXTREME} axis_style_t;
	typedef enum bit {IDLE_RANDOM, IDLE_NONE} idle_style_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push, full, empty, pop;
	sample_t sample_bus;
	result_t result_bus;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	gyro_motion_distance_tracker_core #(.WINDOW_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample_bus),
		.empty(empty),
		.pop(pop),
		.result(result_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Model copy of the configuration and the tracking state.
	logic [MOTION_TH_W-1:0] motion_limit;
	logic [STEP_TH_W-1:0]   step_limit_sq;
	logic [SCALE_W-1:0]     mm_scale;
	longint                 window [DEPTH][AXES];
	int                     window_slot;
	longint                 window_sum [AXES];
	longint                 reference_sum [AXES];
	bit                     measuring_next;
	int unsigned            step_total;
	logic [TOTAL_W-1:0]     magnitude_total;

	sample_t samples_to_send [$];
	result_t readings_due [$];
	int error_count = 0;
	idle_style_t idle_style = IDLE_RANDOM;
	int hold_requests = 0;

	// Floor square root, one result bit per pass.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// Update the model with one accepted sample and queue the reading it causes.
	task automatic compute_step_result(input sample_t s);
		result_t r;
		longint rate [AXES];
		longint d;
		longint m;
		logic [63:0] sq;
		logic [63:0] mag;
		logic [63:0] grown;
		logic [79:0] product;
		rate[0] = s.sample_x;
		rate[1] = s.sample_y;
		rate[2] = s.sample_z;
		for (int a = 0; a < AXES; a++) begin
			window_sum[a] += rate[a] - window[window_slot][a];
			window[window_slot][a] = rate[a];
		end
		window_slot = (window_slot + 1) % DEPTH;
		mag = '0;
		r.distance_taken = 1'b0;
		if (!measuring_next) begin
			for (int a = 0; a < AXES; a++) begin
				m = (window_sum[a] < 0) ? -window_sum[a] : window_sum[a];
				if (m >= longint'(motion_limit))
					measuring_next = 1'b1;
			end
		end else begin
			sq = '0;
			for (int a = 0; a < AXES; a++) begin
				d = window_sum[a] - reference_sum[a];
				if (d < 0)
					d = -d;
				sq += d * d;
				reference_sum[a] = window_sum[a];
			end
			mag = floor_sqrt(sq);
			if (sq >= 64'(step_limit_sq) && step_total < 65535)
				step_total++;
			grown = 64'(magnitude_total) + mag;
			if (grown > 64'hFFFF_FFFF_FFFF)
				magnitude_total = '1;
			else
				magnitude_total = grown[TOTAL_W-1:0];
			r.distance_taken = 1'b1;
			measuring_next = 1'b0;
		end
		r.measuring = measuring_next;
		r.step_magnitude = (mag > 64'hFFFFF) ? '1 : mag[MAG_OUT_W-1:0];
		r.step_count = step_total[COUNT_W-1:0];
		product = magnitude_total * mm_scale;
		product = product >> 32;
		r.total_distance_mm = (product > 80'hFFFF_FFFF) ? '1 : product[DIST_W-1:0];
		readings_due.push_back(r);
	endtask

	function automatic int draw_gap();
		return (idle_style == IDLE_NONE) ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_axis(input axis_style_t st);
		case (st)
			GEN_QUIET: return 16'($urandom_range(0, 400) - 200);
			GEN_WIDE: return 16'($urandom);
			default: begin
				case ($urandom_range(0, 4))
					0: return RATE_MAX;
					1: return RATE_MIN;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
		endcase
	endfunction

	function automatic sample_t make_sample(input axis_style_t st);
		sample_t s;
		s.sample_x = draw_axis(st);
		s.sample_y = draw_axis(st);
		s.sample_z = draw_axis(st);
		return s;
	endfunction

	task automatic queue_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
			input logic [SAMPLE_W-1:0] z);
		sample_t s;
		s.sample_x = x;
		s.sample_y = y;
		s.sample_z = z;
		samples_to_send.push_back(s);
	endtask

	// Mostly sustained rotations that fill the window, with quiet stretches and odd spikes.
	task automatic queue_random_motion(input int count);
		int left;
		int run;
		int kind;
		sample_t s;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				s = make_sample(GEN_WIDE);
				run = $urandom_range(2, 8);
				repeat (run) samples_to_send.push_back(s);
			end else if (kind < 9) begin
				run = $urandom_range(1, 6);
				repeat (run) samples_to_send.push_back(make_sample(GEN_QUIET));
			end else begin
				run = 1;
				samples_to_send.push_back(make_sample(GEN_EXTREME));
			end
			left -= run;
		end
	endtask

	// Register writes happen only while the block is idle.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_MOTION_THRESHOLD: motion_limit = value[MOTION_TH_W-1:0];
			REG_STEP_THRESHOLD_SQ: step_limit_sq = value[STEP_TH_W-1:0];
			REG_DISTANCE_SCALE: mm_scale = value[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	// Wait for every queued sample to be sent and every reading to come back, then settle.
	task automatic drain();
		while (samples_to_send.size() != 0 || push || readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Sample driver: offers the next queued sample after a random gap.
	bit offering = 1'b0;
	int tx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (offering && !full) begin
				compute_step_result(sample_bus);
				offering = 1'b0;
				tx_gap = draw_gap();
			end
			if (!offering) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (samples_to_send.size() != 0) begin
					sample_bus <= samples_to_send.pop_front();
					offering = 1'b1;
				end
			end
			push <= offering;
		end
	end

	// Result monitor: pops with random stalls and compares each transaction.
	int rx_gap = 0;
	int rx_hold = 0;
	int holds_served = 0;
	result_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (readings_due.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual %h", $time,
						result_bus);
				end else begin
					want = readings_due.pop_front();
					report_field("measuring", want.measuring, result_bus.measuring);
					report_field("distance_taken", want.distance_taken,
						result_bus.distance_taken);
					report_field("step_magnitude", want.step_magnitude,
						result_bus.step_magnitude);
					report_field("step_count", want.step_count, result_bus.step_count);
					report_field("total_distance_mm", want.total_distance_mm,
						result_bus.total_distance_mm);
				end
				rx_gap = draw_gap();
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: too many cycles without any transaction ends the run.
	int stall_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("gyro_motion_distance_tracker_core verification failed");
			$finish;
		end
	end

	// Stimulus: directed corners, then random phases under several register settings.
	initial begin
		logic [CFG_W-1:0] value;
		arst_n <= 1'b0;
		push <= 1'b0;
		pop <= 1'b0;
		sample_bus <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		motion_limit = MOTION_TH_RST;
		step_limit_sq = STEP_TH_RST;
		mm_scale = SCALE_RST;
		foreach (window[i, a]) window[i][a] = 0;
		window_slot = 0;
		foreach (window_sum[a]) begin
			window_sum[a] = 0;
			reference_sum[a] = 0;
		end
		measuring_next = 1'b0;
		step_total = 0;
		magnitude_total = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a quiet sample, then full-scale swings that trigger and measure.
		queue_sample(16'sd0, 16'sd0, 16'sd0);
		queue_sample(RATE_MAX, RATE_MAX, RATE_MAX);
		queue_sample(RATE_MIN, RATE_MIN, RATE_MIN);
		queue_sample(16'sd1, -16'sd1, 16'sd0);
		drain();

		// Zero motion threshold, every squared distance a step, largest scale.
		write_register(REG_MOTION_THRESHOLD, '0);
		write_register(REG_STEP_THRESHOLD_SQ, '0);
		write_register(REG_DISTANCE_SCALE, {7'h7F, 32'hFFFF_FFFF});
		write_register(REG_UNUSED, 39'({$urandom, $urandom}));
		repeat (6) queue_sample(RATE_MAX, RATE_MAX, RATE_MAX);
		queue_sample(RATE_MAX, RATE_MIN, 16'sd0);
		queue_sample(-16'sd1, 16'sd1, -16'sd1);
		queue_sample(16'h5555, 16'hAAAA, 16'h5555);
		queue_sample(16'hAAAA, 16'h5555, 16'hAAAA);
		drain();

		// Motion threshold of 196608: only a full negative window starts a measurement.
		write_register(REG_MOTION_THRESHOLD, {21'($urandom), 18'd196608});
		write_register(REG_STEP_THRESHOLD_SQ, STEP_SQ_MAX);
		write_register(REG_DISTANCE_SCALE, '0);
		repeat (6) queue_sample(RATE_MIN, RATE_MIN, RATE_MIN);
		queue_sample(RATE_MAX, RATE_MAX, RATE_MAX);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 3))
				0: value = '0;
				1: value = 39'($urandom_range(0, 1000));
				2: value = 39'($urandom_range(0, 196608));
				default: value = 39'd196608;
			endcase
			value[CFG_W-1:MOTION_TH_W] = 21'($urandom);
			write_register(REG_MOTION_THRESHOLD, value);
			case ($urandom_range(0, 3))
				0: value = 39'($urandom_range(0, 1 << 20));
				1: value = 39'($urandom);
				2: value = 39'({$urandom, $urandom});
				default: value = 39'($urandom_range(0, 1 << 30)) << 8;
			endcase
			write_register(REG_STEP_THRESHOLD_SQ, value);
			write_register(REG_DISTANCE_SCALE, 39'({$urandom, $urandom}));
			for (int chunk = 0; chunk < 4; chunk++) begin
				idle_style = ($urandom_range(0, 3) == 0) ? IDLE_NONE : IDLE_RANDOM;
				// Back pressure: the receiver stops long enough for the block to fill.
				if (phase == 2 && chunk == 1) begin
					idle_style = IDLE_NONE;
					hold_requests++;
				end
				queue_random_motion(30);
				while (samples_to_send.size() != 0)
					@(posedge clk);
			end
			drain();
		end

		if (readings_due.size() != 0) begin
			error_count++;
			$display("%0t: %0d expected results never arrived", $time, readings_due.size());
		end
		if (error_count == 0)
			$display("gyro_motion_distance_tracker_core verification clean");
		else
			$display("gyro_motion_distance_tracker_core verification failed");
		$finish;
	end

endmodule
